// ===== hdl/fsi_pkg.sv =====
// Shared constants, codes and types of the fuzzy speed inference block.
package fsi_pkg;

	localparam int FRAC_BITS_DEF = 8;

	localparam int TEMP_W   = 12;
	localparam int CLOUD_W  = 11;
	localparam int X_W      = 13;
	localparam int OFS_W    = 10;
	localparam int CFG_W    = 8;
	localparam int SPEED_W  = 12;
	localparam int SPD_FRAC = 4;
	localparam int CAT_W    = 2;
	localparam int STR_W    = 9;

	localparam int T_FRZ_LO  = 0 * 16;
	localparam int T_FRZ_HI  = 50 * 16;
	localparam int T_COOL_LO = 30 * 16;
	localparam int T_COOL_PK = 50 * 16;
	localparam int T_COOL_HI = 70 * 16;
	localparam int T_WARM_LO = 50 * 16;
	localparam int T_WARM_PK = 70 * 16;
	localparam int T_WARM_HI = 90 * 16;
	localparam int T_HOT_LO  = 70 * 16;
	localparam int T_HOT_HI  = 110 * 16;
	localparam int C_SUN_LO  = 0 * 16;
	localparam int C_SUN_HI  = 40 * 16;
	localparam int C_CLD_LO  = 20 * 16;
	localparam int C_CLD_PK  = 50 * 16;
	localparam int C_CLD_HI  = 80 * 16;
	localparam int C_OVC_LO  = 60 * 16;
	localparam int C_OVC_HI  = 100 * 16;

	localparam logic [CLOUD_W-1:0] CLOUD_MAX = 11'd1600;

	localparam logic [SPEED_W-1:0] CAT_STOP_MAX = 12'd240;
	localparam logic [SPEED_W-1:0] CAT_SLOW_MAX = 12'd560;
	localparam logic [SPEED_W-1:0] CAT_MED_MAX  = 12'd1200;

	localparam logic [CFG_W-1:0] STOP_SPEED_RST   = 8'd0;
	localparam logic [CFG_W-1:0] SLOW_SPEED_RST   = 8'd25;
	localparam logic [CFG_W-1:0] MEDIUM_SPEED_RST = 8'd50;
	localparam logic [CFG_W-1:0] FAST_SPEED_RST   = 8'd100;

	typedef enum logic [1:0] {
		SHAPE_RISE,
		SHAPE_FALL,
		SHAPE_TRI
	} shape_t;

	typedef enum logic [1:0] {
		REG_STOP   = 2'd0,
		REG_SLOW   = 2'd1,
		REG_MEDIUM = 2'd2,
		REG_FAST   = 2'd3
	} cfg_reg_t;

	typedef enum logic [CAT_W-1:0] {
		CAT_STOP   = 2'd0,
		CAT_SLOW   = 2'd1,
		CAT_MEDIUM = 2'd2,
		CAT_FAST   = 2'd3
	} category_t;

endpackage

// ===== hdl/fsi_in_if.sv =====
// Sample channel: temperature and cloud cover words.
interface fsi_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [fsi_pkg::TEMP_W-1:0] temperature;
	logic [fsi_pkg::CLOUD_W-1:0]       cloud_cover;

	modport source (output valid, output temperature, output cloud_cover, input ready);
	modport sink (input valid, input temperature, input cloud_cover, output ready);
endinterface

// ===== hdl/fsi_out_if.sv =====
// Result channel: speed, category and the four set strengths.
interface fsi_out_if;
	logic                         valid;
	logic                         ready;
	logic [fsi_pkg::SPEED_W-1:0]  speed;
	logic [fsi_pkg::CAT_W-1:0]    category;
	logic [fsi_pkg::STR_W-1:0]    stop_strength;
	logic [fsi_pkg::STR_W-1:0]    slow_strength;
	logic [fsi_pkg::STR_W-1:0]    medium_strength;
	logic [fsi_pkg::STR_W-1:0]    fast_strength;

	modport source (output valid, output speed, output category, output stop_strength,
		output slow_strength, output medium_strength, output fast_strength, input ready);
	modport sink (input valid, input speed, input category, input stop_strength,
		input slow_strength, input medium_strength, input fast_strength, output ready);
endinterface

// ===== hdl/fsi_cfg_if.sv =====
// Configuration write channel: register index and data word.
interface fsi_cfg_if;
	logic                      valid;
	logic                      ready;
	fsi_pkg::cfg_reg_t         index;
	logic [fsi_pkg::CFG_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/fsi_member.sv =====
// Three-stage membership grade of one fuzzy set: region check, reciprocal multiply, select.
module fsi_member #(
	parameter int              FRAC_BITS = fsi_pkg::FRAC_BITS_DEF,
	parameter fsi_pkg::shape_t SHAPE     = fsi_pkg::SHAPE_TRI,
	parameter int              LO        = 0,
	parameter int              PK        = 1,
	parameter int              HI        = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [2:0]                      en,
	input  logic signed [fsi_pkg::X_W-1:0]  x,
	output logic [FRAC_BITS:0]              grade
);

	localparam int XW   = fsi_pkg::X_W;
	localparam int OW   = fsi_pkg::OFS_W;
	localparam int DA   = (SHAPE == fsi_pkg::SHAPE_TRI) ? PK - LO : HI - LO;
	localparam int DB   = (SHAPE == fsi_pkg::SHAPE_TRI) ? HI - PK : HI - LO;
	localparam int DMIN = (DA < DB) ? DA : DB;
	localparam int N_W  = OW + FRAC_BITS;
	localparam int K    = 2 * OW + FRAC_BITS;
	localparam int MW   = K + 1 - $clog2(DMIN);
	localparam int P_W  = N_W + MW;
	localparam logic [63:0] M_A = ((64'd1 << K) + 64'(DA) - 64'd1) / 64'(DA);
	localparam logic [63:0] M_B = ((64'd1 << K) + 64'(DB) - 64'd1) / 64'(DB);
	localparam logic signed [XW-1:0] LO_V = XW'(LO);
	localparam logic signed [XW-1:0] PK_V = XW'(PK);
	localparam logic signed [XW-1:0] HI_V = XW'(HI);
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	typedef struct packed {
		logic sat;
		logic full;
		logic hi_side;
	} grade_ctl_t;

	logic                  below_lo;
	logic                  above_hi;
	logic                  at_pk;
	logic                  left_of_pk;
	logic signed [XW:0]    rise_ofs;
	logic signed [XW:0]    fall_ofs;
	logic [XW:0]           ofs;
	grade_ctl_t            ctl;
	grade_ctl_t            ctl_s1;
	grade_ctl_t            ctl_s2;
	logic [OW-1:0]         ofs_s1;
	logic [N_W-1:0]        numer;
	logic [MW-1:0]         recip;
	logic [P_W-1:0]        prod;
	logic [P_W-1:0]        prod_s2;
	logic [FRAC_BITS:0]    grade_s3;

	always_comb begin
		below_lo   = x <= LO_V;
		above_hi   = x >= HI_V;
		at_pk      = x == PK_V;
		left_of_pk = x < PK_V;
		rise_ofs   = {x[XW-1], x} - {LO_V[XW-1], LO_V};
		fall_ofs   = {HI_V[XW-1], HI_V} - {x[XW-1], x};
		unique case (SHAPE)
			fsi_pkg::SHAPE_RISE: begin
				ctl.sat     = below_lo || above_hi;
				ctl.full    = above_hi;
				ctl.hi_side = 1'b0;
				ofs         = rise_ofs;
			end
			fsi_pkg::SHAPE_FALL: begin
				ctl.sat     = below_lo || above_hi;
				ctl.full    = below_lo;
				ctl.hi_side = 1'b0;
				ofs         = fall_ofs;
			end
			default: begin
				ctl.sat     = below_lo || above_hi || at_pk;
				ctl.full    = at_pk && !below_lo && !above_hi;
				ctl.hi_side = !left_of_pk;
				ofs         = left_of_pk ? rise_ofs : fall_ofs;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			if (en[0]) ctl_s1 <= ctl;
			if (en[1]) ctl_s2 <= ctl_s1;
		end
	end

	assign numer = {ofs_s1, {FRAC_BITS{1'b0}}};
	assign recip = ctl_s1.hi_side ? M_B[MW-1:0] : M_A[MW-1:0];
	assign prod  = numer * recip;

	always_ff @(posedge clk) begin
		if (en[0]) ofs_s1 <= ofs[OW-1:0];
		if (en[1]) prod_s2 <= prod;
		if (en[2]) begin
			if (ctl_s2.sat) grade_s3 <= ctl_s2.full ? ONE : '0;
			else grade_s3 <= {1'b0, prod_s2[K +: FRAC_BITS]};
		end
	end

	assign grade = grade_s3;

endmodule

// ===== hdl/fsi_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side word carried along.
module fsi_divider #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 11,
	parameter int QUO_W = fsi_pkg::SPEED_W,
	parameter int TAG_W = 1
) (
	input  logic              clk,
	input  logic [QUO_W-1:0]  en,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [TAG_W-1:0]  tag,
	output logic [QUO_W-1:0]  quo,
	output logic [TAG_W-1:0]  tag_out
);

	localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

	logic [CW-1:0]    rem_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [TAG_W-1:0] tag_s [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		logic [CW-1:0]    rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic [TAG_W-1:0] tag_in;
		logic [CW-1:0]    trial;
		logic             fits;

		if (i == 0) begin : g_head
			assign rem_in = CW'(num);
			assign den_in = den;
			assign quo_in = '0;
			assign tag_in = tag;
		end else begin : g_body
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
			assign tag_in = tag_s[i-1];
		end

		assign trial = CW'(den_in) << (QUO_W - 1 - i);
		assign fits  = rem_in >= trial;

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_s[i] <= fits ? rem_in - trial : rem_in;
				den_s[i] <= den_in;
				quo_s[i] <= {quo_in[QUO_W-2:0], fits};
				tag_s[i] <= tag_in;
			end
		end
	end

	assign quo     = quo_s[QUO_W-1];
	assign tag_out = tag_s[QUO_W-1];

endmodule

// ===== hdl/fuzzy_two_input_speed_inference_top.sv =====
// Fuzzy two-input speed inference: top level with rule stages, weighting and output register.
//
// Takes one temperature/cloud sample per cycle and returns, in the same order, the
// defuzzified speed in sixteenths of km/h, its category and the four set strengths.
// Throughput is one word per cycle when not stalled. From acceptance to the result
// channel a word passes three membership stages (reciprocal multiply), rule
// evaluation, weighting, summing, twelve stages of the pipelined divider (one quotient
// bit each) and the output register. Bubbles collapse on a stall, so the sample channel
// stays ready until every stage holds a word and the result is not taken. Speed
// registers are written through the configuration channel, always ready, and should be
// written only while no sample is in flight.
module fuzzy_two_input_speed_inference_top #(
	parameter int FRAC_BITS = fsi_pkg::FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	fsi_in_if.sink   sample,
	fsi_out_if.source result,
	fsi_cfg_if.sink  cfg
);

	localparam int SW     = FRAC_BITS + 1;
	localparam int CW8    = fsi_pkg::CFG_W;
	localparam int PW     = SW + CW8;
	localparam int NUM_W  = PW + 2;
	localparam int DEN_W  = SW + 2;
	localparam int DIVN_W = NUM_W + fsi_pkg::SPD_FRAC;
	localparam int QW     = fsi_pkg::SPEED_W;
	localparam int STW    = fsi_pkg::STR_W;
	localparam int TAG_W  = 1 + 4 * STW;
	localparam int DEPTH  = 6 + QW;
	localparam int XW     = fsi_pkg::X_W;

	function automatic logic [SW-1:0] fmin(input logic [SW-1:0] a, input logic [SW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [SW-1:0] fmax(input logic [SW-1:0] a, input logic [SW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [STW-1:0] to_field(input logic [SW-1:0] s);
		logic [SW+STW-1:0] w;
		w = {{STW{1'b0}}, s};
		return w[STW-1:0];
	endfunction

	logic [CW8-1:0] stop_speed_q;
	logic [CW8-1:0] slow_speed_q;
	logic [CW8-1:0] medium_speed_q;
	logic [CW8-1:0] fast_speed_q;

	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0] en;
	logic             out_en;
	logic             out_vld_q;

	logic signed [XW-1:0]          x_temp;
	logic signed [XW-1:0]          x_cloud;
	logic [fsi_pkg::CLOUD_W-1:0]   cloud_clamped;

	logic [SW-1:0] frz, cool, warm, hot, sun, cld, ovc;

	logic [SW-1:0]    stop_s4, slow_s4, med_s4, fast_s4;
	logic [PW-1:0]    stop_p_s5, slow_p_s5, med_p_s5, fast_p_s5;
	logic [DEN_W-1:0] den_s5;
	logic [4*STW-1:0] str_s5;
	logic [NUM_W-1:0] num_s6;
	logic [DEN_W-1:0] den_s6;
	logic [4*STW-1:0] str_s6;

	logic [QW-1:0]    quo;
	logic [TAG_W-1:0] tag_out;
	logic             den_zero;
	logic [QW-1:0]    speed_c;

	logic [QW-1:0]               speed_q;
	fsi_pkg::category_t          cat_q;
	logic [4*STW-1:0]            str_q;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_speed_q   <= fsi_pkg::STOP_SPEED_RST;
			slow_speed_q   <= fsi_pkg::SLOW_SPEED_RST;
			medium_speed_q <= fsi_pkg::MEDIUM_SPEED_RST;
			fast_speed_q   <= fsi_pkg::FAST_SPEED_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				fsi_pkg::REG_STOP:   stop_speed_q   <= cfg.data;
				fsi_pkg::REG_SLOW:   slow_speed_q   <= cfg.data;
				fsi_pkg::REG_MEDIUM: medium_speed_q <= cfg.data;
				fsi_pkg::REG_FAST:   fast_speed_q   <= cfg.data;
				default:             stop_speed_q   <= stop_speed_q;
			endcase
		end
	end

	// stage enables: a stage advances unless it and every stage after it are full and stalled
	assign out_en = !out_vld_q || result.ready;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			en[i] = out_en || ((vld_q | DEPTH'((64'd1 << i) - 64'd1)) != '1);
		end
	end

	assign sample.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (en[0]) vld_q[0] <= sample.valid;
			for (int i = 1; i < DEPTH; i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
			if (out_en) out_vld_q <= vld_q[DEPTH-1];
		end
	end

	// input conditioning
	assign cloud_clamped = (sample.cloud_cover > fsi_pkg::CLOUD_MAX) ?
		fsi_pkg::CLOUD_MAX : sample.cloud_cover;
	assign x_temp  = {sample.temperature[fsi_pkg::TEMP_W-1], sample.temperature};
	assign x_cloud = {2'b00, cloud_clamped};

	// membership grades, stages 1 to 3
	fsi_member #(.FRAC_BITS(FRAC_BITS), .SHAPE(fsi_pkg::SHAPE_FALL),
		.LO(fsi_pkg::T_FRZ_LO), .PK(fsi_pkg::T_FRZ_LO), .HI(fsi_pkg::T_FRZ_HI))
	u_frz (.clk(clk), .arst_n(arst_n), .en(en[2:0]), .x(x_temp), .grade(frz));

	fsi_member #(.FRAC_BITS(FRAC_BITS), .SHAPE(fsi_pkg::SHAPE_TRI),
		.LO(fsi_pkg::T_COOL_LO), .PK(fsi_pkg::T_COOL_PK), .HI(fsi_pkg::T_COOL_HI))
	u_cool (.clk(clk), .arst_n(arst_n), .en(en[2:0]), .x(x_temp), .grade(cool));

	fsi_member #(.FRAC_BITS(FRAC_BITS), .SHAPE(fsi_pkg::SHAPE_TRI),
		.LO(fsi_pkg::T_WARM_LO), .PK(fsi_pkg::T_WARM_PK), .HI(fsi_pkg::T_WARM_HI))
	u_warm (.clk(clk), .arst_n(arst_n), .en(en[2:0]), .x(x_temp), .grade(warm));

	fsi_member #(.FRAC_BITS(FRAC_BITS), .SHAPE(fsi_pkg::SHAPE_RISE),
		.LO(fsi_pkg::T_HOT_LO), .PK(fsi_pkg::T_HOT_HI), .HI(fsi_pkg::T_HOT_HI))
	u_hot (.clk(clk), .arst_n(arst_n), .en(en[2:0]), .x(x_temp), .grade(hot));

	fsi_member #(.FRAC_BITS(FRAC_BITS), .SHAPE(fsi_pkg::SHAPE_FALL),
		.LO(fsi_pkg::C_SUN_LO), .PK(fsi_pkg::C_SUN_LO), .HI(fsi_pkg::C_SUN_HI))
	u_sun (.clk(clk), .arst_n(arst_n), .en(en[2:0]), .x(x_cloud), .grade(sun));

	fsi_member #(.FRAC_BITS(FRAC_BITS), .SHAPE(fsi_pkg::SHAPE_TRI),
		.LO(fsi_pkg::C_CLD_LO), .PK(fsi_pkg::C_CLD_PK), .HI(fsi_pkg::C_CLD_HI))
	u_cld (.clk(clk), .arst_n(arst_n), .en(en[2:0]), .x(x_cloud), .grade(cld));

	fsi_member #(.FRAC_BITS(FRAC_BITS), .SHAPE(fsi_pkg::SHAPE_RISE),
		.LO(fsi_pkg::C_OVC_LO), .PK(fsi_pkg::C_OVC_HI), .HI(fsi_pkg::C_OVC_HI))
	u_ovc (.clk(clk), .arst_n(arst_n), .en(en[2:0]), .x(x_cloud), .grade(ovc));

	// rules, weighting and sums, stages 4 to 6
	always_ff @(posedge clk) begin
		if (en[3]) begin
			slow_s4 <= fmax(fmax(fmin(frz, sun), fmin(cool, sun)),
				fmax(fmin(cool, cld), fmin(cool, ovc)));
			med_s4  <= fmax(fmax(fmin(warm, sun), fmin(warm, cld)), fmin(warm, ovc));
			fast_s4 <= fmax(fmax(fmin(hot, sun), fmin(hot, cld)), fmin(hot, ovc));
			stop_s4 <= fmax(fmin(frz, cld), fmin(frz, ovc));
		end
		if (en[4]) begin
			stop_p_s5 <= PW'(stop_s4) * PW'(stop_speed_q);
			slow_p_s5 <= PW'(slow_s4) * PW'(slow_speed_q);
			med_p_s5  <= PW'(med_s4) * PW'(medium_speed_q);
			fast_p_s5 <= PW'(fast_s4) * PW'(fast_speed_q);
			den_s5    <= DEN_W'(stop_s4) + DEN_W'(slow_s4) + DEN_W'(med_s4)
				+ DEN_W'(fast_s4);
			str_s5    <= {to_field(stop_s4), to_field(slow_s4), to_field(med_s4),
				to_field(fast_s4)};
		end
		if (en[5]) begin
			num_s6 <= NUM_W'(stop_p_s5) + NUM_W'(slow_p_s5) + NUM_W'(med_p_s5)
				+ NUM_W'(fast_p_s5);
			den_s6 <= den_s5;
			str_s6 <= str_s5;
		end
	end

	// division, stages 7 to 18
	fsi_divider #(.NUM_W(DIVN_W), .DEN_W(DEN_W), .QUO_W(QW), .TAG_W(TAG_W)) u_div (
		.clk     (clk),
		.en      (en[DEPTH-1:6]),
		.num     ({num_s6, {fsi_pkg::SPD_FRAC{1'b0}}}),
		.den     (den_s6),
		.tag     ({den_s6 == '0, str_s6}),
		.quo     (quo),
		.tag_out (tag_out)
	);

	assign den_zero = tag_out[TAG_W-1];
	assign speed_c  = den_zero ? '0 : quo;

	// output register
	always_ff @(posedge clk) begin
		if (out_en) begin
			speed_q <= speed_c;
			str_q   <= tag_out[4*STW-1:0];
			if (speed_c <= fsi_pkg::CAT_STOP_MAX) cat_q <= fsi_pkg::CAT_STOP;
			else if (speed_c <= fsi_pkg::CAT_SLOW_MAX) cat_q <= fsi_pkg::CAT_SLOW;
			else if (speed_c <= fsi_pkg::CAT_MED_MAX) cat_q <= fsi_pkg::CAT_MEDIUM;
			else cat_q <= fsi_pkg::CAT_FAST;
		end
	end

	assign result.valid           = out_vld_q;
	assign result.speed           = speed_q;
	assign result.category        = cat_q;
	assign result.stop_strength   = str_q[4*STW-1:3*STW];
	assign result.slow_strength   = str_q[3*STW-1:2*STW];
	assign result.medium_strength = str_q[2*STW-1:STW];
	assign result.fast_strength   = str_q[STW-1:0];

	a_cat_band: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
			((result.speed <= fsi_pkg::CAT_STOP_MAX) == (result.category == fsi_pkg::CAT_STOP))
			&& ((result.speed > fsi_pkg::CAT_MED_MAX) == (result.category == fsi_pkg::CAT_FAST)))
		else $error("category does not match speed band");

	a_no_rule_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(FRAC_BITS <= 8) && result.valid && (result.stop_strength == '0)
			&& (result.slow_strength == '0) && (result.medium_strength == '0)
			&& (result.fast_strength == '0) |-> result.speed == '0)
		else $error("nonzero speed with no rule firing");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> result.valid && !result.ready && (vld_q == '1))
		else $error("sample channel held off with room in the pipeline");

endmodule
